/* sv/lbpp_pkg.sv */
`default_nettype none
package lbpp_pkg;

   // pattern table geometry
   localparam int MAX_PAIRS   = 10;
   localparam int TABLE_WORDS = 2 * MAX_PAIRS;
   localparam int PIDX_W      = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int IDX_W       = PIDX_W + 1;

   // fixed field widths
   localparam int OP_W    = 2;
   localparam int SLOT_W  = 5;
   localparam int DUR_W   = 16;
   localparam int TOTAL_W = 4;
   localparam int LIMIT_W = 16;

   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_START = 2'd2,
      OP_FORCE = 2'd3
   } op_type;

   typedef struct packed {
      logic               fire;
      op_type             opcode;
      logic [TOTAL_W-1:0] pair_total;
      logic [LIMIT_W-1:0] repeat_limit;
      logic               level;
   } cmd_type;

   typedef struct packed {
      logic led;
      logic running;
   } status_type;

endpackage
`default_nettype wire

/* sv/lbpp_table.sv */
`default_nettype none
module lbpp_table (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [lbpp_pkg::SLOT_W-1:0] wr_slot,
   input  wire logic [lbpp_pkg::DUR_W-1:0]  wr_data,
   input  wire logic [lbpp_pkg::IDX_W-1:0]  rd_idx,
   output logic      [lbpp_pkg::DUR_W-1:0]  rd_data
);
   import lbpp_pkg::*;

   // on/off durations; word 2p is on time of pair p, 2p+1 its off time
   logic [DUR_W-1:0] words_ff [TABLE_WORDS];

   always_ff @(posedge clock) begin
      if (wr_en && (int'(wr_slot) < TABLE_WORDS)) begin
         words_ff[IDX_W'(wr_slot)] <= wr_data;
      end
   end

   assign rd_data = words_ff[rd_idx];

endmodule
`default_nettype wire

/* sv/lbpp_ctrl.sv */
`default_nettype none
module lbpp_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lbpp_pkg::cmd_type          cmd,
   input  wire logic [lbpp_pkg::DUR_W-1:0] phase_dur,
   output logic      [lbpp_pkg::IDX_W-1:0] rd_idx,
   output lbpp_pkg::status_type            status
);
   import lbpp_pkg::*;

   localparam int PAIR_W = $clog2(MAX_PAIRS + 1);

   logic [PIDX_W-1:0]  pair_index_ff,  pair_index_in;
   logic               off_phase_ff,   off_phase_in;
   logic [DUR_W-1:0]   ticks_ff,       ticks_in;
   logic [LIMIT_W-1:0] passes_ff,      passes_in;
   logic [LIMIT_W-1:0] pass_limit_ff,  pass_limit_in;
   logic [PAIR_W-1:0]  pairs_ff,       pairs_in;
   logic               playing_ff,     playing_in;
   logic               led_ff,         led_in;

   logic [DUR_W-1:0]   phase_len;
   logic [DUR_W:0]     ticks_inc;
   logic [PAIR_W:0]    pair_next;

   assign rd_idx    = {pair_index_ff, off_phase_ff};
   assign phase_len = (phase_dur == '0) ? DUR_W'(1) : phase_dur;
   assign ticks_inc = {1'b0, ticks_ff} + (DUR_W+1)'(1);
   assign pair_next = (PAIR_W+1)'(pair_index_ff) + (PAIR_W+1)'(1);

   always_comb begin
      pair_index_in = pair_index_ff;
      off_phase_in  = off_phase_ff;
      ticks_in      = ticks_ff;
      passes_in     = passes_ff;
      pass_limit_in = pass_limit_ff;
      pairs_in      = pairs_ff;
      playing_in    = playing_ff;
      led_in        = led_ff;
      if (cmd.fire) begin
         unique case (cmd.opcode)
            OP_TICK: begin
               if (playing_ff) begin
                  if (ticks_inc >= {1'b0, phase_len}) begin
                     ticks_in = '0;
                     if (!off_phase_ff) begin
                        off_phase_in = 1'b1;
                        led_in       = 1'b0;
                     end else begin
                        off_phase_in = 1'b0;
                        led_in       = 1'b1;
                        if (pair_next >= {1'b0, pairs_ff}) begin
                           pair_index_in = '0;
                           if (pass_limit_ff != '0) begin
                              if (passes_ff < pass_limit_ff) begin
                                 passes_in = passes_ff + LIMIT_W'(1);
                              end else begin
                                 playing_in = 1'b0;
                                 passes_in  = '0;
                                 led_in     = 1'b0;
                              end
                           end
                        end else begin
                           pair_index_in = PIDX_W'(pair_next);
                        end
                     end
                  end else begin
                     ticks_in = ticks_inc[DUR_W-1:0];
                  end
               end
            end
            OP_WRITE: begin
               // table handled by lbpp_table
            end
            OP_START: begin
               if (cmd.pair_total == '0) begin
                  playing_in = 1'b0;
               end else begin
                  if (int'(cmd.pair_total) > MAX_PAIRS) begin
                     pairs_in = PAIR_W'(MAX_PAIRS);
                  end else begin
                     pairs_in = PAIR_W'(cmd.pair_total);
                  end
                  pass_limit_in = cmd.repeat_limit;
                  passes_in     = '0;
                  pair_index_in = '0;
                  off_phase_in  = 1'b0;
                  ticks_in      = '0;
                  playing_in    = 1'b1;
                  led_in        = 1'b1;
               end
            end
            OP_FORCE: begin
               led_in     = cmd.level;
               playing_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_index_ff <= '0;
         off_phase_ff  <= 1'b0;
         ticks_ff      <= '0;
         passes_ff     <= '0;
         pass_limit_ff <= '0;
         pairs_ff      <= '0;
         playing_ff    <= 1'b0;
         led_ff        <= 1'b0;
      end else begin
         pair_index_ff <= pair_index_in;
         off_phase_ff  <= off_phase_in;
         ticks_ff      <= ticks_in;
         passes_ff     <= passes_in;
         pass_limit_ff <= pass_limit_in;
         pairs_ff      <= pairs_in;
         playing_ff    <= playing_in;
         led_ff        <= led_in;
      end
   end

   assign status.led     = led_ff;
   assign status.running = playing_ff;

endmodule
`default_nettype wire

/* sv/led_blink_pattern_player_unit.sv */
// LED blink pattern player. Each req_ transfer carries one command: a tick,
// a table word write, a start (pair count and repeat limit) or a force of
// the LED level. Every command yields exactly one rsp_ transfer giving the
// LED level and the running flag as they stand after that command. One
// command is taken per clock cycle while the result register is free or
// draining: the update (table read, tick compare, counter increments) is
// combinational between the command port and the state/result registers,
// so each result shows in the cycle after its command is taken. req_ready
// stays high while the result register is empty or being drained in the
// same cycle, so a new command enters while the previous result is taken.
// Table words are undefined after reset and must be written before a
// pattern plays them; no clearing pass is run.
`default_nettype none
module led_blink_pattern_player_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [lbpp_pkg::OP_W-1:0]     req_opcode,
   input  wire logic [lbpp_pkg::SLOT_W-1:0]   req_slot,
   input  wire logic [lbpp_pkg::DUR_W-1:0]    req_duration,
   input  wire logic [lbpp_pkg::TOTAL_W-1:0]  req_pair_total,
   input  wire logic [lbpp_pkg::LIMIT_W-1:0]  req_repeat_limit,
   input  wire logic                          req_level,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_led_level,
   output logic                               rsp_running
);
   import lbpp_pkg::*;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   cmd_type           cmd;
   status_type        status;
   logic [IDX_W-1:0]  rd_idx;
   logic [DUR_W-1:0]  rd_data;

   // room for a new result when empty or when the held one leaves now
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign cmd.fire         = accept;
   assign cmd.opcode       = op_type'(req_opcode);
   assign cmd.pair_total   = req_pair_total;
   assign cmd.repeat_limit = req_repeat_limit;
   assign cmd.level        = req_level;

   lbpp_table u_table (
      .clock   (clock),
      .wr_en   (accept && (op_type'(req_opcode) == OP_WRITE)),
      .wr_slot (req_slot),
      .wr_data (req_duration),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   // state registers double as the result register: they only move on
   // an accepted command, which needs the result slot free
   lbpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .phase_dur (rd_data),
      .rd_idx    (rd_idx),
      .status    (status)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_led_level = status.led;
   assign rsp_running   = status.running;

endmodule
`default_nettype wire
